// File: hw/rtl/tsgd_pkg.sv
// Shared types, codes and reset values for the touch stroke gesture detector.
// Holds the gesture state update helpers used by the core. No dependencies.
`timescale 1ns / 1ps

package tsgd_pkg;

	localparam int STAGE_WIDTH_DEF  = 192;
	localparam int STAGE_HEIGHT_DEF = 192;

	// action codes
	localparam logic [2:0] ACT_PRESS   = 3'd0;
	localparam logic [2:0] ACT_SAMPLE  = 3'd1;
	localparam logic [2:0] ACT_RELEASE = 3'd2;
	localparam logic [2:0] ACT_POLL    = 3'd3;
	localparam logic [2:0] ACT_CANCEL  = 3'd4;
	localparam logic [2:0] ACT_PREEMPT = 3'd5;

	// gesture phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_CAND   = 2'd1;
	localparam logic [1:0] PH_STROKE = 2'd2;
	localparam logic [1:0] PH_REL    = 2'd3;

	// reported events
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_START  = 2'd1;
	localparam logic [1:0] EV_END    = 2'd2;
	localparam logic [1:0] EV_CANCEL = 2'd3;

	// register indexes
	localparam logic [2:0] REG_HEAD_BOX       = 3'd0;
	localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd1;
	localparam logic [2:0] REG_DWELL_TIME     = 3'd2;
	localparam logic [2:0] REG_GENTLE_TIME    = 3'd3;
	localparam logic [2:0] REG_RELEASE_TIME   = 3'd4;
	localparam logic [2:0] REG_LEAVE_TIME     = 3'd5;
	localparam logic [2:0] REG_DIST_LIMITS    = 3'd6;
	localparam logic [2:0] REG_INSIDE_PERCENT = 3'd7;

	// register reset values
	localparam logic [31:0] HEAD_BOX_RST       = 32'd1611307558;
	localparam logic [15:0] SAMPLE_PERIOD_RST  = 16'd100;
	localparam logic [15:0] DWELL_TIME_RST     = 16'd650;
	localparam logic [15:0] GENTLE_TIME_RST    = 16'd350;
	localparam logic [15:0] RELEASE_TIME_RST   = 16'd150;
	localparam logic [15:0] LEAVE_TIME_RST     = 16'd250;
	localparam logic [63:0] DIST_LIMITS_RST    = 64'd22518685332406284;
	localparam logic [6:0]  INSIDE_PERCENT_RST = 7'd70;

	localparam logic [6:0]  PCT_FULL = 7'd100;

	typedef struct packed {
		logic [7:0]  left;
		logic [7:0]  right;
		logic [7:0]  top;
		logic [7:0]  bottom;
		logic [15:0] sample_period;
		logic [15:0] dwell_time;
		logic [15:0] gentle_time;
		logic [15:0] release_time;
		logic [15:0] leave_time;
		logic [15:0] stat_max;
		logic [15:0] gentle_min;
		logic [15:0] gentle_max;
		logic [15:0] step_max;
		logic [6:0]  inside_pct;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic               consumed;
		logic               outside;
		logic signed [15:0] last_x;
		logic signed [15:0] last_y;
		logic [31:0]        start_mark;
		logic [31:0]        sample_mark;
		logic [31:0]        outside_mark;
		logic [31:0]        release_mark;
		logic [31:0]        path_length;
		logic [15:0]        sample_total;
		logic [15:0]        inside_total;
	} st_t;

	typedef struct packed {
		st_t        st;
		logic [1:0] ev;
	} step_t;

	// end the gesture: idle, consumed set as given, outside cleared, rest kept
	function automatic step_t finish(st_t st, logic was_consumed);
		step_t r;
		r.st          = st;
		r.st.phase    = PH_IDLE;
		r.st.consumed = was_consumed;
		r.st.outside  = 1'b0;
		r.ev          = was_consumed ? EV_END : EV_CANCEL;
		return r;
	endfunction

	// timed checks of a poll tick; caller has already checked the configuration
	function automatic step_t poll(st_t st, cfg_t c, logic [31:0] now);
		step_t       r;
		logic [31:0] el;
		logic [22:0] lhs;
		logic [22:0] rhs;
		logic        ratio;
		logic        still;
		logic        gentle;
		r     = '{st: st, ev: EV_NONE};
		el    = now - st.start_mark;
		lhs   = 23'(st.sample_total) * 23'(c.inside_pct);
		rhs   = 23'(st.inside_total) * 23'(PCT_FULL);
		ratio = (st.sample_total != 16'd0) && (lhs <= rhs);
		still = (32'(c.dwell_time) <= el) && (st.path_length <= 32'(c.stat_max))
			&& !st.outside;
		gentle = (32'(c.gentle_time) <= el) && (32'(c.gentle_min) <= st.path_length)
			&& (st.path_length <= 32'(c.gentle_max)) && !st.outside && ratio;
		if (st.phase == PH_CAND) begin
			if (still || gentle) begin
				r.st.phase    = PH_STROKE;
				r.st.consumed = 1'b1;
				r.ev          = EV_START;
			end
		end else if (st.phase == PH_STROKE) begin
			if (st.outside && (32'(c.leave_time) <= (now - st.outside_mark)))
				r = finish(st, 1'b1);
		end else if (st.phase == PH_REL) begin
			if (32'(c.release_time) <= (now - st.release_mark))
				r = finish(st, 1'b1);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/tsgd_cfg.sv
// Configuration register bank and validity check for the stroke detector.
// Depends on tsgd_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module tsgd_cfg
	import tsgd_pkg::*;
#(
	parameter int STAGE_WIDTH  = STAGE_WIDTH_DEF,
	parameter int STAGE_HEIGHT = STAGE_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output cfg_t        cfg,
	output logic        cfg_ok
);

	logic [31:0] head_box_q;
	logic [15:0] sample_period_q;
	logic [15:0] dwell_time_q;
	logic [15:0] gentle_time_q;
	logic [15:0] release_time_q;
	logic [15:0] leave_time_q;
	logic [63:0] dist_limits_q;
	logic [6:0]  inside_pct_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_box_q      <= HEAD_BOX_RST;
			sample_period_q <= SAMPLE_PERIOD_RST;
			dwell_time_q    <= DWELL_TIME_RST;
			gentle_time_q   <= GENTLE_TIME_RST;
			release_time_q  <= RELEASE_TIME_RST;
			leave_time_q    <= LEAVE_TIME_RST;
			dist_limits_q   <= DIST_LIMITS_RST;
			inside_pct_q    <= INSIDE_PERCENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEAD_BOX:       head_box_q      <= cfg_data[31:0];
				REG_SAMPLE_PERIOD:  sample_period_q <= cfg_data[15:0];
				REG_DWELL_TIME:     dwell_time_q    <= cfg_data[15:0];
				REG_GENTLE_TIME:    gentle_time_q   <= cfg_data[15:0];
				REG_RELEASE_TIME:   release_time_q  <= cfg_data[15:0];
				REG_LEAVE_TIME:     leave_time_q    <= cfg_data[15:0];
				REG_DIST_LIMITS:    dist_limits_q   <= cfg_data;
				REG_INSIDE_PERCENT: inside_pct_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.left          = head_box_q[7:0];
		cfg.right         = head_box_q[15:8];
		cfg.top           = head_box_q[23:16];
		cfg.bottom        = head_box_q[31:24];
		cfg.sample_period = sample_period_q;
		cfg.dwell_time    = dwell_time_q;
		cfg.gentle_time   = gentle_time_q;
		cfg.release_time  = release_time_q;
		cfg.leave_time    = leave_time_q;
		cfg.stat_max      = dist_limits_q[15:0];
		cfg.gentle_min    = dist_limits_q[31:16];
		cfg.gentle_max    = dist_limits_q[47:32];
		cfg.step_max      = dist_limits_q[63:48];
		cfg.inside_pct    = inside_pct_q;
	end

	// box in stage and ordered, timers nonzero, gentle min<=max, pct<=100
	assign cfg_ok = ({1'b0, head_box_q[15:8]} < 9'(STAGE_WIDTH))
		&& ({1'b0, head_box_q[31:24]} < 9'(STAGE_HEIGHT))
		&& (head_box_q[15:8] >= head_box_q[7:0])
		&& (head_box_q[31:24] >= head_box_q[23:16])
		&& (sample_period_q != 16'd0) && (dwell_time_q != 16'd0)
		&& (gentle_time_q != 16'd0) && (release_time_q != 16'd0)
		&& (leave_time_q != 16'd0)
		&& (dist_limits_q[47:32] >= dist_limits_q[31:16])
		&& (inside_pct_q <= PCT_FULL);

endmodule

// File: hw/rtl/tsgd_core.sv
// Gesture state machine with input and result registers.
// Depends on tsgd_pkg for codes, cfg_t, st_t and the poll/finish helpers.
`timescale 1ns / 1ps

module tsgd_core
	import tsgd_pkg::*;
#(
	parameter int STAGE_WIDTH  = STAGE_WIDTH_DEF,
	parameter int STAGE_HEIGHT = STAGE_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cfg_ok,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // pos_x, pos_y, now_ms
	input  logic [2:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // event_res, press_accepted, phase_out, consumed
);

	logic               in_valid_s1;
	logic [2:0]         act_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic [31:0]        now_s1;

	logic               out_valid_s2;
	logic [1:0]         ev_s2;
	logic               acc_s2;
	logic [1:0]         phase_s2;
	logic               cons_s2;

	st_t                state_q;
	step_t              res;
	logic               acc;
	logic               advance;

	logic               in_stage;
	logic               in_head;
	logic signed [16:0] dx_s;
	logic signed [16:0] dy_s;
	logic [15:0]        adx;
	logic [15:0]        ady;
	logic [16:0]        step_d;
	logic [32:0]        psum;
	st_t                upd;

	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_axis_tready)
			in_valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			act_s1 <= s_axis_tuser;
			x_s1   <= s_axis_tdata[15:0];
			y_s1   <= s_axis_tdata[31:16];
			now_s1 <= s_axis_tdata[63:32];
		end
	end

	assign in_stage = !x_s1[15] && !y_s1[15]
		&& ({1'b0, x_s1} < 17'(STAGE_WIDTH)) && ({1'b0, y_s1} < 17'(STAGE_HEIGHT));
	assign in_head = in_stage
		&& (16'(cfg.left) <= x_s1) && (x_s1 <= 16'(cfg.right))
		&& (16'(cfg.top) <= y_s1) && (y_s1 <= 16'(cfg.bottom));

	assign dx_s   = 17'(x_s1) - 17'(state_q.last_x);
	assign dy_s   = 17'(y_s1) - 17'(state_q.last_y);
	assign adx    = dx_s[16] ? 16'(-dx_s) : 16'(dx_s);
	assign ady    = dy_s[16] ? 16'(-dy_s) : 16'(dy_s);
	assign step_d = {1'b0, adx} + {1'b0, ady};
	assign psum   = {1'b0, state_q.path_length} + 33'(step_d);

	// state after an accepted motion sample, before the end and poll checks
	always_comb begin
		upd             = state_q;
		upd.last_x      = x_s1;
		upd.last_y      = y_s1;
		upd.sample_mark = now_s1;
		upd.path_length = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
		if (state_q.sample_total != 16'hFFFF)
			upd.sample_total = state_q.sample_total + 16'd1;
		if (in_head) begin
			if (state_q.inside_total != 16'hFFFF)
				upd.inside_total = state_q.inside_total + 16'd1;
			upd.outside = 1'b0;
		end else if (!state_q.outside) begin
			upd.outside      = 1'b1;
			upd.outside_mark = now_s1;
		end
	end

	always_comb begin
		res = '{st: state_q, ev: EV_NONE};
		acc = 1'b0;
		unique case (act_s1)
			ACT_PRESS: begin
				if (cfg_ok) begin
					res.st = '0;
					if (in_head) begin
						res.st.phase        = PH_CAND;
						res.st.last_x       = x_s1;
						res.st.last_y       = y_s1;
						res.st.start_mark   = now_s1;
						res.st.sample_mark  = now_s1;
						res.st.sample_total = 16'd1;
						res.st.inside_total = 16'd1;
						acc                 = 1'b1;
					end
				end
			end
			ACT_SAMPLE: begin
				if (cfg_ok && (state_q.phase == PH_CAND || state_q.phase == PH_STROKE)) begin
					if (!in_stage)
						res = finish(state_q, state_q.phase == PH_STROKE);
					else if (32'(cfg.sample_period) > (now_s1 - state_q.sample_mark))
						res = poll(state_q, cfg, now_s1);
					else if (state_q.phase == PH_CAND && ((17'(cfg.step_max) < step_d)
						|| (32'(cfg.gentle_max) < upd.path_length)))
						res = finish(upd, 1'b0);
					else if (state_q.phase == PH_STROKE && (17'(cfg.step_max) < step_d))
						res = finish(upd, 1'b1);
					else
						res = poll(upd, cfg, now_s1);
				end
			end
			ACT_RELEASE: begin
				if (state_q.phase == PH_CAND) begin
					res    = finish(state_q, 1'b0);
					res.ev = EV_NONE;
				end else if (state_q.phase == PH_STROKE) begin
					res.st.phase        = PH_REL;
					res.st.release_mark = now_s1;
					res.st.consumed     = 1'b1;
				end
			end
			ACT_POLL: begin
				if (cfg_ok)
					res = poll(state_q, cfg, now_s1);
			end
			ACT_CANCEL: begin
				if (state_q.phase != PH_IDLE)
					res = finish(state_q, state_q.phase == PH_STROKE
						|| state_q.phase == PH_REL || state_q.consumed);
			end
			ACT_PREEMPT: begin
				if (state_q.phase != PH_IDLE)
					res = finish(state_q, 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (advance)
			state_q <= res.st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (advance)
			out_valid_s2 <= 1'b1;
		else if (m_axis_tready)
			out_valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2    <= res.ev;
			acc_s2   <= acc;
			phase_s2 <= res.st.phase;
			cons_s2  <= res.st.consumed;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {2'b00, cons_s2, phase_s2, acc_s2, ev_s2};

	a_start_strokes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && ev_s2 == EV_START |-> phase_s2 == PH_STROKE && cons_s2)
		else $error("start event without stroking phase");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && (ev_s2 == EV_END || ev_s2 == EV_CANCEL) |-> phase_s2 == PH_IDLE)
		else $error("end event left phase active");

	a_press_cand: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && acc_s2 |-> phase_s2 == PH_CAND && ev_s2 == EV_NONE)
		else $error("accepted press without candidate phase");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a transaction");

endmodule

// File: hw/rtl/touch_stroke_gesture_detector.sv
// Touch stroke gesture detector: top level tying configuration bank and core.
// Depends on tsgd_pkg, tsgd_cfg and tsgd_core.
// Path: input register, one pass of compare/add logic, then the result register.
// Throughput: one item per cycle while m_axis_tready stays high; a stalled result
// holds both registers and, while the input register holds a transaction, drops
// s_axis_tready in the same cycle.
// Reset: arst_n clears the gesture state to idle and loads register defaults.
`timescale 1ns / 1ps

module touch_stroke_gesture_detector
	import tsgd_pkg::*;
#(
	parameter int STAGE_WIDTH  = STAGE_WIDTH_DEF,   // stage width in pixels, 1..256
	parameter int STAGE_HEIGHT = STAGE_HEIGHT_DEF   // stage height in pixels, 1..256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// touch events in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [15:0] pos_x, [31:16] pos_y, [63:32] now_ms
	input  logic [2:0]  s_axis_tuser,  // [2:0] action
	// one result per event out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [1:0] event_res, [2] press_accepted,
	                                   // [4:3] phase_out, [5] consumed, [7:6] zero
);

	cfg_t cfg;
	logic cfg_ok;

	// Hold the register bank; validity is decoded combinationally so a press
	// right after a write sees the new configuration.
	tsgd_cfg #(
		.STAGE_WIDTH  (STAGE_WIDTH),
		.STAGE_HEIGHT (STAGE_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cfg_ok    (cfg_ok)
	);

	// Advance the gesture state once per transaction that moves from the
	// input register into the result register.
	tsgd_core #(
		.STAGE_WIDTH  (STAGE_WIDTH),
		.STAGE_HEIGHT (STAGE_HEIGHT)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cfg_ok        (cfg_ok),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: bench/touch_stroke_gesture_detector_tb.sv
// Self-checking bench for touch_stroke_gesture_detector: streams touch events, predicts
// every result with an independent gesture tracker and checks them in order.
// Depends on tsgd_pkg and the detector RTL only.
`timescale 1ns / 1ps

module touch_stroke_gesture_detector_tb;
	import tsgd_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 6;     // margin past the input and result registers

	// action codes the block leaves alone
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        now;
	} touch_t;

	typedef struct packed {
		logic [1:0] ev;
		logic       acc;
		logic [1:0] phase;
		logic       consumed;
	} report_t;

	typedef struct packed {
		logic [7:0]  box_l;
		logic [7:0]  box_r;
		logic [7:0]  box_t;
		logic [7:0]  box_b;
		logic [15:0] period;
		logic [15:0] dwell;
		logic [15:0] gentle;
		logic [15:0] rel;
		logic [15:0] leave;
		logic [15:0] stat_max;
		logic [15:0] gmin;
		logic [15:0] gmax;
		logic [15:0] step_max;
		logic [6:0]  pct;
	} settings_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic               consumed;
		logic               outside;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic [31:0]        t_start;
		logic [31:0]        t_sample;
		logic [31:0]        t_out;
		logic [31:0]        t_rel;
		logic [31:0]        path;
		logic [15:0]        n_samp;
		logic [15:0]        n_in;
	} gesture_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [63:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;  // [15:0] pos_x, [31:16] pos_y, [63:32] now_ms
	logic [2:0]  s_axis_tuser  = '0;  // [2:0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [1:0] event_res, [2] press_accepted,
	                                  // [4:3] phase_out, [5] consumed

	// mirror of the register bank and of the gesture tracker
	settings_t settings;
	gesture_t  g;

	touch_t  touch_backlog[$];    // events waiting for the driver
	report_t gesture_reports[$];  // predicted results, oldest first
	touch_t  cur_touch;
	bit      presenting = 1'b0;

	logic [31:0] clock_ms = '0;
	int items_queued       = 0;
	int items_sent         = 0;
	int results_checked    = 0;
	int cfg_writes         = 0;
	int fail_count         = 0;
	int strokes_started    = 0;
	int strokes_ended      = 0;
	int gestures_cancelled = 0;

	int          burst_left  = 0;
	int          gap_left    = 0;
	logic [15:0] accept_mask = '1;
	logic [31:0] stall_cycle = '0;

	always #5 clk = ~clk;

	touch_stroke_gesture_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// ------------------------------------------------------------------
	// Gesture tracker: predicts one result per accepted touch event
	// ------------------------------------------------------------------

	function automatic void reg_apply(logic [2:0] idx, logic [63:0] v);
		case (idx)
			REG_HEAD_BOX:       {settings.box_b, settings.box_t, settings.box_r, settings.box_l} = v[31:0];
			REG_SAMPLE_PERIOD:  settings.period = v[15:0];
			REG_DWELL_TIME:     settings.dwell = v[15:0];
			REG_GENTLE_TIME:    settings.gentle = v[15:0];
			REG_RELEASE_TIME:   settings.rel = v[15:0];
			REG_LEAVE_TIME:     settings.leave = v[15:0];
			REG_DIST_LIMITS:    {settings.step_max, settings.gmax, settings.gmin, settings.stat_max} = v;
			REG_INSIDE_PERCENT: settings.pct = v[6:0];
			default: ;
		endcase
	endfunction

	function automatic bit settings_valid();
		if (int'(settings.box_r) >= STAGE_WIDTH_DEF || int'(settings.box_b) >= STAGE_HEIGHT_DEF)
			return 1'b0;
		if (settings.box_r < settings.box_l || settings.box_b < settings.box_t)
			return 1'b0;
		if (settings.period == 0 || settings.dwell == 0 || settings.gentle == 0 ||
			settings.rel == 0 || settings.leave == 0)
			return 1'b0;
		if (settings.gmax < settings.gmin)
			return 1'b0;
		return settings.pct <= 7'd100;
	endfunction

	function automatic bit on_stage(int xi, int yi);
		return xi >= 0 && yi >= 0 && xi < STAGE_WIDTH_DEF && yi < STAGE_HEIGHT_DEF;
	endfunction

	function automatic bit in_head(int xi, int yi);
		return on_stage(xi, yi) &&
			int'(settings.box_l) <= xi && xi <= int'(settings.box_r) &&
			int'(settings.box_t) <= yi && yi <= int'(settings.box_b);
	endfunction

	// every end of a gesture: back to idle, consumed set to kept, outside flag dropped, the rest kept
	function automatic logic [1:0] close_gesture(bit kept);
		g.phase    = PH_IDLE;
		g.consumed = kept;
		g.outside  = 1'b0;
		return kept ? EV_END : EV_CANCEL;
	endfunction

	// time-driven checks shared by poll ticks and accepted samples
	function automatic logic [1:0] tick_check(logic [31:0] now);
		logic [31:0] el;
		logic [31:0] lhs;
		logic [31:0] rhs;
		bit          ratio;
		bit          still;
		bit          gentle;
		if (!settings_valid())
			return EV_NONE;
		el  = now - g.t_start;
		lhs = {16'd0, g.n_samp} * {25'd0, settings.pct};
		rhs = {16'd0, g.n_in} * 32'd100;
		if (g.phase == PH_CAND) begin
			ratio  = g.n_samp != 0 && lhs <= rhs;
			still  = settings.dwell <= el && g.path <= settings.stat_max && !g.outside;
			gentle = settings.gentle <= el && settings.gmin <= g.path &&
				g.path <= settings.gmax && !g.outside && ratio;
			if (still || gentle) begin
				g.phase    = PH_STROKE;
				g.consumed = 1'b1;
				return EV_START;
			end
			return EV_NONE;
		end
		if (g.phase == PH_STROKE && g.outside && settings.leave <= now - g.t_out)
			return close_gesture(1'b1);
		if (g.phase == PH_REL && settings.rel <= now - g.t_rel)
			return close_gesture(1'b1);
		return EV_NONE;
	endfunction

	function automatic logic [1:0] sample_move(logic signed [15:0] x, logic signed [15:0] y,
		logic [31:0] now);
		int          xi;
		int          yi;
		int          lxi;
		int          lyi;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] step;
		xi  = int'(x);
		yi  = int'(y);
		lxi = int'(g.lx);
		lyi = int'(g.ly);
		if (!settings_valid() || (g.phase != PH_CAND && g.phase != PH_STROKE))
			return EV_NONE;
		if (!on_stage(xi, yi))
			return close_gesture(g.phase == PH_STROKE);
		// too soon after the last accepted sample: treat as a poll tick
		if (settings.period > now - g.t_sample)
			return tick_check(now);
		dx   = (xi >= lxi) ? xi - lxi : lxi - xi;
		dy   = (yi >= lyi) ? yi - lyi : lyi - yi;
		step = dx + dy;
		g.lx       = x;
		g.ly       = y;
		g.t_sample = now;
		if (32'hFFFF_FFFF - g.path < step)
			g.path = '1;
		else
			g.path = g.path + step;
		if (g.n_samp != 16'hFFFF)
			g.n_samp = g.n_samp + 16'd1;
		if (in_head(xi, yi)) begin
			if (g.n_in != 16'hFFFF)
				g.n_in = g.n_in + 16'd1;
			g.outside = 1'b0;
		end else if (!g.outside) begin
			g.outside = 1'b1;
			g.t_out   = now;
		end
		if (g.phase == PH_CAND && (settings.step_max < step || settings.gmax < g.path))
			return close_gesture(1'b0);
		if (g.phase == PH_STROKE && settings.step_max < step)
			return close_gesture(1'b1);
		return tick_check(now);
	endfunction

	function automatic report_t track_gesture(touch_t t);
		report_t r;
		r = '0;
		case (t.action)
			ACT_PRESS: begin
				if (settings_valid()) begin
					g = '0;
					if (in_head(int'(t.x), int'(t.y))) begin
						g.phase    = PH_CAND;
						g.lx       = t.x;
						g.ly       = t.y;
						g.t_start  = t.now;
						g.t_sample = t.now;
						g.n_samp   = 16'd1;
						g.n_in     = 16'd1;
						r.acc      = 1'b1;
					end
				end
			end
			ACT_SAMPLE: r.ev = sample_move(t.x, t.y, t.now);
			ACT_RELEASE: begin
				// a release in candidate drops the gesture silently
				if (g.phase == PH_CAND) begin
					void'(close_gesture(1'b0));
				end else if (g.phase == PH_STROKE) begin
					g.phase    = PH_REL;
					g.t_rel    = t.now;
					g.consumed = 1'b1;
				end
			end
			ACT_POLL: r.ev = tick_check(t.now);
			ACT_CANCEL: begin
				if (g.phase != PH_IDLE)
					r.ev = close_gesture(g.phase == PH_STROKE || g.phase == PH_REL || g.consumed);
			end
			ACT_PREEMPT: begin
				if (g.phase != PH_IDLE)
					r.ev = close_gesture(1'b1);
			end
			default: ;
		endcase
		r.phase    = g.phase;
		r.consumed = g.consumed;
		if (r.ev == EV_START)
			strokes_started++;
		else if (r.ev == EV_END)
			strokes_ended++;
		else if (r.ev == EV_CANCEL)
			gestures_cancelled++;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: present backlog events in bursts with random gaps
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !presenting) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (touch_backlog.size() > 0) begin
				cur_touch  = touch_backlog.pop_front();
				presenting = 1'b1;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {cur_touch.now, cur_touch.y, cur_touch.x};
				s_axis_tuser  <= cur_touch.action;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// new burst; a quarter of them run back to back
					burst_left = $urandom_range(0, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall on a rotating mask, reshuffled whenever stall_cycle[7:0] wraps to zero
	always @(negedge clk) begin
		stall_cycle = stall_cycle + 1;
		if (stall_cycle[7:0] == 8'd0) begin
			case ($urandom_range(0, 3))
				0: accept_mask = '1;
				1: accept_mask = 16'h0001;
				default: accept_mask = 16'($urandom) | 16'h0001;
			endcase
		end
		m_axis_tready <= accept_mask[stall_cycle[3:0]];
	end

	// ------------------------------------------------------------------
	// Monitor: check results, then predict the event taken at this edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		report_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (gesture_reports.size() == 0) begin
					$error("result with no prediction waiting: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = gesture_reports.pop_front();
					results_checked++;
					if (m_axis_tdata[1:0] !== want.ev) begin
						$error("event_res: expected %0d, actual %0d", want.ev, m_axis_tdata[1:0]);
						fail_count++;
					end
					if (m_axis_tdata[2] !== want.acc) begin
						$error("press_accepted: expected %0d, actual %0d", want.acc,
							m_axis_tdata[2]);
						fail_count++;
					end
					if (m_axis_tdata[4:3] !== want.phase) begin
						$error("phase_out: expected %0d, actual %0d", want.phase,
							m_axis_tdata[4:3]);
						fail_count++;
					end
					if (m_axis_tdata[5] !== want.consumed) begin
						$error("consumed: expected %0d, actual %0d", want.consumed,
							m_axis_tdata[5]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				gesture_reports.push_back(track_gesture(cur_touch));
				presenting = 1'b0;
				items_sent++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_touch(logic [2:0] a, int x, int y, logic [31:0] t);
		touch_t item;
		item.action = a;
		item.x      = x[15:0];
		item.y      = y[15:0];
		item.now    = t;
		touch_backlog.push_back(item);
		items_queued++;
	endtask

	// write one register; the mirror follows at the transaction
	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_apply(idx, v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pack_box(int l, int r, int t, int b);
		return {32'd0, b[7:0], t[7:0], r[7:0], l[7:0]};
	endfunction

	function automatic logic [63:0] pack_limits(int stat, int gmin, int gmax, int step);
		return {step[15:0], gmax[15:0], gmin[15:0], stat[15:0]};
	endfunction

	task automatic load_config(logic [63:0] box, int period, int dwell, int gentle, int rel,
		int leave, logic [63:0] limits, int pct);
		write_reg(REG_HEAD_BOX, box);
		write_reg(REG_SAMPLE_PERIOD, 64'(period[15:0]));
		write_reg(REG_DWELL_TIME, 64'(dwell[15:0]));
		write_reg(REG_GENTLE_TIME, 64'(gentle[15:0]));
		write_reg(REG_RELEASE_TIME, 64'(rel[15:0]));
		write_reg(REG_LEAVE_TIME, 64'(leave[15:0]));
		write_reg(REG_DIST_LIMITS, limits);
		write_reg(REG_INSIDE_PERCENT, 64'(pct[6:0]));
	endtask

	task automatic nominal_config();
		load_config(pack_box(30, 160, 20, 150), 80, 500, 300, 120, 200,
			pack_limits(10, 8, 200, 60), 65);
	endtask

	// push one register out of its legal range; which selects the flaw
	task automatic break_setting(int which);
		case (which)
			0: write_reg(REG_HEAD_BOX, pack_box(10, $urandom_range(192, 255), 20, 150));
			1: write_reg(REG_HEAD_BOX, pack_box(120, 40, 20, 150));
			2: write_reg(REG_HEAD_BOX, 64'h0000_0000_FFFF_FFFF);
			3: write_reg(REG_SAMPLE_PERIOD, 64'd0);
			4, 5, 6, 7: write_reg(3'(int'(REG_DWELL_TIME) + which - 4), 64'd0);
			8: write_reg(REG_DIST_LIMITS, pack_limits($urandom_range(0, 30), 200, 199,
				$urandom_range(1, 100)));
			default: write_reg(REG_INSIDE_PERCENT, 64'($urandom_range(101, 127)));
		endcase
	endtask

	task automatic random_settings();
		int l;
		int r;
		int t;
		int b;
		int gmin;
		l    = $urandom_range(0, 150);
		r    = $urandom_range(l, STAGE_WIDTH_DEF - 1);
		t    = $urandom_range(0, 150);
		b    = $urandom_range(t, STAGE_HEIGHT_DEF - 1);
		gmin = $urandom_range(0, 40);
		load_config(pack_box(l, r, t, b), $urandom_range(1, 250), $urandom_range(1, 900),
			$urandom_range(1, 600), $urandom_range(1, 400), $urandom_range(1, 500),
			pack_limits($urandom_range(0, 30), gmin, gmin + $urandom_range(0, 300),
				$urandom_range(1, 150)),
			$urandom_range(0, 100));
		if ($urandom_range(0, 3) == 0)
			break_setting($urandom_range(0, 9));
	endtask

	// hold until the block has answered everything, then wait SETTLE_CYCLES more
	task automatic drain();
		while (touch_backlog.size() != 0 || presenting || gesture_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] sample_span();
		// now and then a sample arrives inside the sample period
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, settings.period);
		return settings.period + $urandom_range(0, settings.period / 2);
	endfunction

	function automatic logic [31:0] pause_span();
		logic [31:0] thr;
		case ($urandom_range(0, 3))
			0: thr = 32'(settings.dwell);
			1: thr = 32'(settings.gentle);
			2: thr = 32'(settings.rel);
			default: thr = 32'(settings.leave);
		endcase
		return $urandom_range(0, thr + thr / 2 + 1);
	endfunction

	// one press-to-end gesture with random motion, timing and ending
	task automatic make_gesture();
		int lo_x;
		int hi_x;
		int lo_y;
		int hi_y;
		int cx;
		int cy;
		int amp;
		int steps;
		int pick;
		if (settings.box_l <= settings.box_r && int'(settings.box_r) < STAGE_WIDTH_DEF &&
			settings.box_t <= settings.box_b && int'(settings.box_b) < STAGE_HEIGHT_DEF) begin
			lo_x = int'(settings.box_l);
			hi_x = int'(settings.box_r);
			lo_y = int'(settings.box_t);
			hi_y = int'(settings.box_b);
		end else begin
			lo_x = 0;
			hi_x = STAGE_WIDTH_DEF - 1;
			lo_y = 0;
			hi_y = STAGE_HEIGHT_DEF - 1;
		end
		cx = $urandom_range(lo_x, hi_x);
		cy = $urandom_range(lo_y, hi_y);
		clock_ms = clock_ms + $urandom_range(1, 500);
		queue_touch(ACT_PRESS, cx, cy, clock_ms);
		// motion style: stationary, gentle, loose, near the step limit, wild
		pick = $urandom_range(0, 9);
		if (pick < 3)
			amp = 0;
		else if (pick < 7)
			amp = $urandom_range(1, 4);
		else if (pick == 7)
			amp = $urandom_range(0, 20);
		else if (pick == 8)
			amp = int'(settings.step_max) / 2 + 1;
		else
			amp = $urandom_range(0, 60);
		steps = $urandom_range(1, 10);
		repeat (steps) begin
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				if (pick == 11) begin
					cx = hi_x + $urandom_range(1, 30);        // step out of the head box
				end else if (pick == 12) begin
					cy = $urandom_range(0, 1) ? -1 : STAGE_HEIGHT_DEF + $urandom_range(0, 9);
				end else begin
					cx = cx + int'($urandom_range(0, 2 * amp)) - amp;
					cy = cy + int'($urandom_range(0, 2 * amp)) - amp;
				end
				clock_ms = clock_ms + sample_span();
				queue_touch(ACT_SAMPLE, cx, cy, clock_ms);
			end else if (pick < 19) begin
				clock_ms = clock_ms + pause_span();
				queue_touch(ACT_POLL, cx, cy, clock_ms);
			end else begin
				clock_ms = clock_ms + sample_span();
				queue_touch(ACT_RELEASE, cx, cy, clock_ms);
			end
		end
		pick = $urandom_range(0, 7);
		if (pick < 4) begin
			clock_ms = clock_ms + sample_span();
			queue_touch(ACT_RELEASE, cx, cy, clock_ms);
			repeat ($urandom_range(1, 3)) begin
				clock_ms = clock_ms + pause_span();
				queue_touch(ACT_POLL, cx, cy, clock_ms);
			end
		end else if (pick == 4) begin
			queue_touch(ACT_CANCEL, cx, cy, clock_ms + 1);
		end else if (pick == 5) begin
			queue_touch(ACT_PREEMPT, cx, cy, clock_ms + 1);
		end else begin
			// leave the gesture open; the next press restarts it
			clock_ms = clock_ms + pause_span();
			queue_touch(ACT_POLL, cx, cy, clock_ms);
		end
	endtask

	// any action, any coordinates, sometimes a jump in time
	task automatic noise_touch();
		if ($urandom_range(0, 9) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, 2000);
		queue_touch(3'($urandom_range(0, 7)), $urandom, $urandom, clock_ms);
	endtask

	task automatic gesture_burst(int n);
		int start;
		start = items_queued;
		while (items_queued - start < n) begin
			if ($urandom_range(0, 4) == 0)
				noise_touch();
			else
				make_gesture();
		end
	endtask

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("touch_stroke_gesture_detector regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		reg_apply(REG_HEAD_BOX, 64'(HEAD_BOX_RST));
		reg_apply(REG_SAMPLE_PERIOD, 64'(SAMPLE_PERIOD_RST));
		reg_apply(REG_DWELL_TIME, 64'(DWELL_TIME_RST));
		reg_apply(REG_GENTLE_TIME, 64'(GENTLE_TIME_RST));
		reg_apply(REG_RELEASE_TIME, 64'(RELEASE_TIME_RST));
		reg_apply(REG_LEAVE_TIME, 64'(LEAVE_TIME_RST));
		reg_apply(REG_DIST_LIMITS, DIST_LIMITS_RST);
		reg_apply(REG_INSIDE_PERCENT, 64'(INSIDE_PERCENT_RST));
		g = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pass on reset defaults: head box x 38..154, y 10..96.
		// Idle ignores everything but a press, and spare codes do nothing.
		queue_touch(ACT_POLL, 0, 0, 0);
		queue_touch(ACT_SAMPLE, 50, 50, 10);
		queue_touch(ACT_RELEASE, 50, 50, 20);
		queue_touch(ACT_CANCEL, 50, 50, 30);
		queue_touch(ACT_PREEMPT, 50, 50, 40);
		queue_touch(ACT_SPARE_A, -1, -1, 50);
		queue_touch(ACT_SPARE_B, 32767, -32768, 32'hFFFF_FFFF);
		// presses off the stage and off the head are refused
		queue_touch(ACT_PRESS, -32768, 32767, 100);
		queue_touch(ACT_PRESS, 0, 0, 200);
		// release in candidate drops back to idle with no event
		queue_touch(ACT_PRESS, 100, 50, 1000);
		queue_touch(ACT_RELEASE, 100, 50, 1010);
		// early sample acts as a poll, then a dwell starts the stroke,
		// then a sample off the stage ends it
		queue_touch(ACT_PRESS, 100, 50, 2000);
		queue_touch(ACT_SAMPLE, 100, 50, 2050);
		queue_touch(ACT_SAMPLE, 101, 50, 2100);
		queue_touch(ACT_POLL, 0, 0, 2650);
		queue_touch(ACT_SAMPLE, 192, 50, 2800);
		// off the stage from candidate cancels
		queue_touch(ACT_PRESS, 100, 50, 3000);
		queue_touch(ACT_SAMPLE, 32767, -32768, 3100);
		// release timeout after a stroke
		queue_touch(ACT_PRESS, 100, 50, 4000);
		queue_touch(ACT_POLL, 0, 0, 4650);
		queue_touch(ACT_RELEASE, 100, 50, 4700);
		queue_touch(ACT_POLL, 0, 0, 4800);
		queue_touch(ACT_POLL, 0, 0, 4850);
		// preempt in candidate
		queue_touch(ACT_PRESS, 100, 50, 5000);
		queue_touch(ACT_PREEMPT, 100, 50, 5010);
		clock_ms = 6000;
		drain();

		// nominal settings; the sender holds off mid-phase until all is answered
		nominal_config();
		gesture_burst(40);
		drain();
		gesture_burst(40);
		drain();

		// low extremes: full-stage box, one-millisecond times, zero distances
		load_config(pack_box(0, STAGE_WIDTH_DEF - 1, 0, STAGE_HEIGHT_DEF - 1), 1, 1, 1, 1, 1,
			64'd0, 0);
		gesture_burst(60);
		drain();

		// high extremes: one-pixel box, longest times, open limits, across the time wrap
		load_config(pack_box(100, 100, 100, 100), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 100);
		clock_ms = 32'hFFFF_0000;
		gesture_burst(60);
		drain();

		// each flavor of invalid configuration
		for (int which = 0; which < 10; which++) begin
			nominal_config();
			break_setting(which);
			gesture_burst(12);
			drain();
		end

		// random settings
		repeat (5) begin
			random_settings();
			gesture_burst(45);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (gesture_reports.size() != 0) begin
			$error("%0d predicted results never arrived", gesture_reports.size());
			fail_count++;
		end
		$display("covered %0d touch events, %0d results checked, %0d register writes",
			items_sent, results_checked, cfg_writes);
		$display("gestures seen: %0d strokes started, %0d ended, %0d cancelled",
			strokes_started, strokes_ended, gestures_cancelled);
		if (fail_count == 0)
			$display("touch_stroke_gesture_detector regression: pass");
		else
			$display("touch_stroke_gesture_detector regression: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tsgd_pkg.sv
hw/rtl/tsgd_cfg.sv
hw/rtl/tsgd_core.sv
hw/rtl/touch_stroke_gesture_detector.sv
bench/touch_stroke_gesture_detector_tb.sv
